// File: design/par_pkg.sv
`timescale 1ns / 1ps
package par_pkg;

   localparam int CALC_W       = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_ANGLE = 3'd6;

   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30      = 34'sh0_4000_0000;

   typedef enum logic [3:0] {
      ST_LOAD, ST_CORDIC, ST_NORM, ST_SQUARE, ST_SQRT, ST_DIV, ST_MUL, ST_BUILD, ST_READY
   } gen_state_type;

   typedef struct packed {
      logic [2:0][CALC_W-1:0] axis;
      logic [31:0]            phase;
   } cfg_type;

   typedef struct packed {
      logic [2:0][2:0][CALC_W-1:0] r;
      logic                        axis_zero;
   } mat_type;

   function automatic logic [31:0] arc_entry(input logic [4:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2F9;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

   function automatic logic signed [33:0] clamp_q30(input logic signed [33:0] v);
      logic signed [33:0] r;
      if (v > ONE_Q30) begin
         r = ONE_Q30;
      end else if (v < -ONE_Q30) begin
         r = -ONE_Q30;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/par_matrix_gen.sv
`timescale 1ns / 1ps
module par_matrix_gen (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  par_pkg::cfg_type  cfg,
   output par_pkg::mat_type  mat,
   output logic              ready
);
   import par_pkg::*;

   gen_state_type       state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [1:0]          comp_ff, comp_in;
   logic                neg_ff, neg_in;
   logic signed [33:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [33:0]  cos_ff, cos_in, sin_ff, sin_in;
   logic [31:0]         mag_ff [3];
   logic [31:0]         mag_in [3];
   logic [2:0]          sgn_ff, sgn_in;
   logic [63:0]         sum_ff, sum_in, res_ff, res_in, bit_ff, bit_in;
   logic [32:0]         len_ff, len_in;
   logic [63:0]         dvd_ff, dvd_in;
   logic [32:0]         rem_ff, rem_in;
   logic [31:0]         quo_ff, quo_in;
   logic signed [33:0]  n_ff [3];
   logic signed [33:0]  n_in [3];
   logic signed [33:0]  p_ff [6];
   logic signed [33:0]  p_in [6];
   logic signed [33:0]  q_ff [6];
   logic signed [33:0]  q_in [6];
   logic signed [33:0]  w_ff [3];
   logic signed [33:0]  w_in [3];
   mat_type             mat_ff, mat_in;

   logic signed [33:0]  mul_a, mul_b, t_w, mulq_w, dx_w, dy_w, arc_w, fin_w;
   logic signed [67:0]  prod_w;
   logic [31:0]         pf_w, q_fin_w;
   logic signed [31:0]  ax_w;
   logic [63:0]         rb_w, res_nx_w;
   logic [33:0]         rem_s_w;
   logic                qb_w;
   logic signed [33:0]  r_w [3][3];

   assign t_w    = ONE_Q30 - cos_ff;
   assign prod_w = mul_a * mul_b;
   assign mulq_w = 34'((prod_w + 68'sd536870912) >>> 30);
   assign dx_w   = cy_ff >>> cnt_ff[4:0];
   assign dy_w   = cx_ff >>> cnt_ff[4:0];
   assign arc_w  = $signed({2'b00, arc_entry(cnt_ff[4:0])});
   assign rb_w   = res_ff + bit_ff;
   assign rem_s_w = {rem_ff, dvd_ff[63]};
   assign qb_w    = (rem_s_w >= {1'b0, len_ff});
   assign q_fin_w = {quo_ff[30:0], qb_w};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQUARE) begin
         mul_a = $signed({2'b00, mag_ff[cnt_ff[1:0]]});
         mul_b = $signed({2'b00, mag_ff[cnt_ff[1:0]]});
      end else begin
         unique case (cnt_ff[3:0])
            4'd0:  begin mul_a = n_ff[0]; mul_b = n_ff[0]; end
            4'd1:  begin mul_a = n_ff[0]; mul_b = n_ff[1]; end
            4'd2:  begin mul_a = n_ff[0]; mul_b = n_ff[2]; end
            4'd3:  begin mul_a = n_ff[1]; mul_b = n_ff[1]; end
            4'd4:  begin mul_a = n_ff[1]; mul_b = n_ff[2]; end
            4'd5:  begin mul_a = n_ff[2]; mul_b = n_ff[2]; end
            4'd6:  begin mul_a = p_ff[0]; mul_b = t_w; end
            4'd7:  begin mul_a = p_ff[1]; mul_b = t_w; end
            4'd8:  begin mul_a = p_ff[2]; mul_b = t_w; end
            4'd9:  begin mul_a = p_ff[3]; mul_b = t_w; end
            4'd10: begin mul_a = p_ff[4]; mul_b = t_w; end
            4'd11: begin mul_a = p_ff[5]; mul_b = t_w; end
            4'd12: begin mul_a = n_ff[0]; mul_b = sin_ff; end
            4'd13: begin mul_a = n_ff[1]; mul_b = sin_ff; end
            4'd14: begin mul_a = n_ff[2]; mul_b = sin_ff; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_comb begin
      r_w[0][0] = clamp_q30(cos_ff + q_ff[0]);
      r_w[0][1] = clamp_q30(q_ff[1] - w_ff[2]);
      r_w[0][2] = clamp_q30(q_ff[2] + w_ff[1]);
      r_w[1][0] = clamp_q30(q_ff[1] + w_ff[2]);
      r_w[1][1] = clamp_q30(cos_ff + q_ff[3]);
      r_w[1][2] = clamp_q30(q_ff[4] - w_ff[0]);
      r_w[2][0] = clamp_q30(q_ff[2] - w_ff[1]);
      r_w[2][1] = clamp_q30(q_ff[4] + w_ff[0]);
      r_w[2][2] = clamp_q30(cos_ff + q_ff[5]);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      neg_in   = neg_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      mag_in   = mag_ff;
      sgn_in   = sgn_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      len_in   = len_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      n_in     = n_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      w_in     = w_ff;
      mat_in   = mat_ff;
      pf_w     = cfg.phase;
      ax_w     = '0;
      res_nx_w = res_ff >> 1;
      fin_w    = '0;
      unique case (state_ff)
         ST_LOAD: begin
            // fold the phase into the right half plane, negate at the end
            neg_in = cfg.phase[31] ^ cfg.phase[30];
            if (cfg.phase[31] ^ cfg.phase[30]) begin
               pf_w = cfg.phase + 32'h8000_0000;
            end
            cx_in = CORDIC_START;
            cy_in = '0;
            cz_in = 34'($signed(pf_w));
            for (int i = 0; i < 3; i++) begin
               ax_w      = $signed(cfg.axis[i]);
               sgn_in[i] = ax_w[31];
               mag_in[i] = ax_w[31] ? 32'(-ax_w) : 32'(ax_w);
            end
            cnt_in = '0;
            if (cfg.axis == '0) begin
               mat_in.axis_zero = 1'b1;
               state_in = ST_READY;
            end else begin
               mat_in.axis_zero = 1'b0;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - dx_w;
               cy_in = cy_ff + dy_w;
               cz_in = cz_ff - arc_w;
            end else begin
               cx_in = cx_ff + dx_w;
               cy_in = cy_ff - dy_w;
               cz_in = cz_ff + arc_w;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cos_in = clamp_q30(neg_ff ? -cx_ff : cx_ff);
            sin_in = clamp_q30(neg_ff ? -cy_ff : cy_ff);
            if (mag_ff[0][31:30] == 2'b00 && mag_ff[1][31:30] == 2'b00
                && mag_ff[2][31:30] == 2'b00) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sum_in = sum_ff + 64'(prod_w);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               cnt_in   = '0;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sum_ff >= rb_w) begin
               sum_in   = sum_ff - rb_w;
               res_nx_w = (res_ff >> 1) + bit_ff;
            end
            res_in = res_nx_w;
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               len_in   = 33'(res_nx_w);
               comp_in  = '0;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = '0;
               dvd_in   = ({32'b0, mag_ff[0]} << 30) + (res_nx_w >> 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = qb_w ? 33'(rem_s_w - {1'b0, len_ff}) : rem_s_w[32:0];
            quo_in = q_fin_w;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               fin_w = $signed({2'b00, q_fin_w});
               n_in[comp_ff] = sgn_ff[comp_ff] ? -fin_w : fin_w;
               rem_in = '0;
               quo_in = '0;
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  state_in = ST_MUL;
               end else begin
                  comp_in = comp_ff + 2'd1;
                  dvd_in  = ({32'b0, mag_ff[comp_ff + 2'd1]} << 30) + 64'(len_ff >> 1);
               end
            end
         end
         ST_MUL: begin
            unique case (cnt_ff[3:0])
               4'd0:  p_in[0] = mulq_w;
               4'd1:  p_in[1] = mulq_w;
               4'd2:  p_in[2] = mulq_w;
               4'd3:  p_in[3] = mulq_w;
               4'd4:  p_in[4] = mulq_w;
               4'd5:  p_in[5] = mulq_w;
               4'd6:  q_in[0] = mulq_w;
               4'd7:  q_in[1] = mulq_w;
               4'd8:  q_in[2] = mulq_w;
               4'd9:  q_in[3] = mulq_w;
               4'd10: q_in[4] = mulq_w;
               4'd11: q_in[5] = mulq_w;
               4'd12: w_in[0] = mulq_w;
               4'd13: w_in[1] = mulq_w;
               4'd14: w_in[2] = mulq_w;
               default: ;
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd14) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  mat_in.r[i][j] = 32'(r_w[i][j]);
               end
            end
            state_in = ST_READY;
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: state_in = ST_LOAD;
      endcase
      // any register write starts the computation over
      if (restart) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      comp_ff <= comp_in;
      neg_ff  <= neg_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      mag_ff  <= mag_in;
      sgn_ff  <= sgn_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      len_ff  <= len_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      w_ff    <= w_in;
      mat_ff  <= mat_in;
   end

   assign mat   = mat_ff;
   assign ready = (state_ff == ST_READY);

endmodule

// File: design/par_point_pipe.sv
`timescale 1ns / 1ps
module par_point_pipe #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [2:0][par_pkg::CALC_W-1:0]     pos,
   input  logic [2:0][par_pkg::CALC_W-1:0]     ctr,
   input  par_pkg::mat_type                    mat,
   output logic                                out_valid,
   output logic [2:0][COORD_WIDTH-1:0]         out_rot,
   output logic                                out_invalid
);
   import par_pkg::*;

   localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (COORD_WIDTH - 1)) - 40'sd1;
   localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic                    inv1_ff, inv2_ff, inv3_ff, inv4_ff;
   logic [2:0][CALC_W-1:0]  pos1_ff, pos2_ff, pos3_ff;
   logic signed [32:0]      d1_ff [3];
   logic signed [64:0]      prod2_ff [3][3];
   logic signed [66:0]      acc3_ff [3];
   logic signed [66:0]      acc_in [3];
   logic signed [39:0]      v_in [3];
   logic [2:0][COORD_WIDTH-1:0] rot_in, rot4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = 67'(prod2_ff[i][0] >>> 2) + 67'(prod2_ff[i][1] >>> 2)
                   + 67'(prod2_ff[i][2] >>> 2);
         v_in[i] = 40'($signed(ctr[i]))
                 + 40'((acc3_ff[i] + 67'sd134217728) >>> 28);
         if (inv3_ff) begin
            rot_in[i] = COORD_WIDTH'(pos3_ff[i]);
         end else if (v_in[i] > SAT_HI) begin
            rot_in[i] = COORD_WIDTH'(SAT_HI);
         end else if (v_in[i] < SAT_LO) begin
            rot_in[i] = COORD_WIDTH'(SAT_LO);
         end else begin
            rot_in[i] = COORD_WIDTH'(v_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      inv1_ff <= mat.axis_zero;
      pos1_ff <= pos;
      for (int j = 0; j < 3; j++) begin
         d1_ff[j] <= 33'($signed(pos[j])) - 33'($signed(ctr[j]));
      end
      inv2_ff <= inv1_ff;
      pos2_ff <= pos1_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod2_ff[i][j] <= 65'($signed(mat.r[i][j])) * 65'(d1_ff[j]);
         end
      end
      inv3_ff <= inv2_ff;
      pos3_ff <= pos2_ff;
      acc3_ff <= acc_in;
      inv4_ff <= inv3_ff;
      rot4_ff <= rot_in;
   end

   assign out_valid   = v4_ff;
   assign out_rot     = rot4_ff;
   assign out_invalid = inv4_ff;

endmodule

// File: design/point_axis_angle_rotation.sv
// Path: an accepted start reaches rsp_valid via subtract, multiply, sum, saturate registers.
// Throughput: one point per cycle while busy is low; the receiver cannot stall.
// Busy: after reset and after every csr write, the matrix sequencer holds busy high through
// 30 CORDIC steps, up to 30 normalize shifts, 3 squares, 32 square-root steps, three 64-step
// divides and 15 shared multiplies; with a zero axis it goes from load straight to ready.
// Reset: synchronous; clears the pipeline valids and loads the register defaults.
`timescale 1ns / 1ps
module point_axis_angle_rotation #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic                          csr_we,
   input  logic [par_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_wdata,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_z,
   output logic                          rsp_axis_invalid
);
   import par_pkg::*;

   logic [COORD_WIDTH-1:0]      center_ff [3];
   logic [COORD_WIDTH-1:0]      axis_ff [3];
   logic [ANGLE_WIDTH-1:0]      angle_ff;
   cfg_type                     cfg;
   mat_type                     mat;
   logic                        ready;
   logic [2:0][CALC_W-1:0]      pos_w, ctr_w;
   logic [2:0][COORD_WIDTH-1:0] rot_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         axis_ff[0]   <= '0;
         axis_ff[1]   <= '0;
         axis_ff[2]   <= COORD_WIDTH'(65536);
         angle_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CENTER_Y:   center_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_CENTER_Z:   center_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_AXIS_X:     axis_ff[0]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_AXIS_Y:     axis_ff[1]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_AXIS_Z:     axis_ff[2]   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_TURN_ANGLE: angle_ff     <= csr_wdata[ANGLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cfg.axis[i] = CALC_W'($signed(axis_ff[i]));
         ctr_w[i]    = CALC_W'($signed(center_ff[i]));
      end
      cfg.phase = 32'(angle_ff) << (32 - ANGLE_WIDTH);
      pos_w[0]  = CALC_W'(req_pos_x);
      pos_w[1]  = CALC_W'(req_pos_y);
      pos_w[2]  = CALC_W'(req_pos_z);
   end

   par_matrix_gen u_gen (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .cfg     (cfg),
      .mat     (mat),
      .ready   (ready)
   );

   par_point_pipe #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ready),
      .pos         (pos_w),
      .ctr         (ctr_w),
      .mat         (mat),
      .out_valid   (rsp_valid),
      .out_rot     (rot_w),
      .out_invalid (rsp_axis_invalid)
   );

   assign busy      = ~ready;
   assign rsp_rot_x = rot_w[0];
   assign rsp_rot_y = rot_w[1];
   assign rsp_rot_z = rot_w[2];

endmodule

// File: design/par_checker.sv
`timescale 1ns / 1ps
module par_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic csr_we,
   input logic rsp_valid
);

   // every accepted word comes back on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##4 rsp_valid)
      else $error("result missing four cycles after accept");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without matching accept");

   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("not busy after register write");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && busy)
      else $error("reset did not clear outputs");

endmodule

bind point_axis_angle_rotation par_checker u_par_checker (.*);
